// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define MCF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define MCF_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants of the multipath complex FIR unit.
// ----------------------------------------------------------------------------
package mcf_pkg;

	// parameter defaults
	localparam int NUM_PATHS_DEF   = 8;
	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed port widths
	localparam int PATH_W = 3;
	localparam int TIX_W  = 6;
	localparam int VAL_W  = 16;
	localparam int TCNT_W = 7;
	localparam int SUM_W  = 40;

	typedef enum logic {
		CMD_WEIGHT = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic load_weight;
		logic load_sample;
		logic issue;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic path_ok;
		logic clear_last;
		logic issue_last;
		logic pipe_idle;
	} dp_stat_t;

endpackage

// ===== hdl/multipath_complex_fir_unit.sv =====
// ----------------------------------------------------------------------------
// multipath_complex_fir_unit
// Complex tapped delay line with one ring buffer and one weight set per path.
// ----------------------------------------------------------------------------
// Usage:
//   Requests are taken on a rising edge with start high and busy low.
//   cmd = weight: stores value_re/value_im as weight tap_index of path.
//     busy stays low, no result.
//   cmd = sample: pushes the sample into the path's ring (the tap count is
//     latched on the path's first sample) and runs the complex MAC.
//   Requests on a path at or above NUM_PATHS are dropped with no result.
//   Result: sum_re/sum_im valid when done is high for a single cycle, once
//     the MAC pipe has run all T taps, T being the path's tap count.
//     The next request can be taken in the cycle after done.
//   The rate is set by the single shared MAC pipe: one tap per cycle from
//     one read port on each store, plus read, multiply and accumulate stages.
//   The result is kept until the next sample: the receiver takes it in the done cycle.
//   Reset: ring state clears at once; then busy stays high while both
//     stores are swept to zero, one entry per cycle, over all
//     NUM_PATHS * MAX_TAPS entries.
// ----------------------------------------------------------------------------
module multipath_complex_fir_unit import mcf_pkg::*; #(
	parameter int NUM_PATHS   = NUM_PATHS_DEF,
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cmd,
	input  logic [PATH_W-1:0]       path,
	input  logic [TIX_W-1:0]        tap_index,
	input  logic signed [VAL_W-1:0] value_re,
	input  logic signed [VAL_W-1:0] value_im,
	input  logic [TCNT_W-1:0]       tap_count,
	output logic                    done,
	output logic signed [SUM_W-1:0] sum_re,
	output logic signed [SUM_W-1:0] sum_im
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	mcf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	mcf_dp #(
		.NUM_PATHS   (NUM_PATHS),
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.path      (path),
		.tap_index (tap_index),
		.value_re  (value_re),
		.value_im  (value_im),
		.tap_count (tap_count),
		.sum_re    (sum_re),
		.sum_im    (sum_im)
	);

endmodule

// ===== hdl/mcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcf_ctrl
// Sequencer: store clearing after reset, request decode, tap loop, result strobe.
// ----------------------------------------------------------------------------
module mcf_ctrl import mcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cmd,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		ctl.clear_step  = (state_q == ST_CLEAR);
		ctl.load_weight = accept && (cmd == CMD_WEIGHT) && stat.path_ok;
		ctl.load_sample = accept && (cmd == CMD_SAMPLE) && stat.path_ok;
		ctl.issue       = (state_q == ST_MAC);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (ctl.load_sample)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (stat.issue_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// wait for the last products to land in the accumulator
				if (stat.pipe_idle)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== hdl/mcf_dp.sv =====
// ----------------------------------------------------------------------------
// mcf_dp
// Datapath: per-path ring state, delay and weight memories, complex MAC pipe.
// ----------------------------------------------------------------------------
module mcf_dp import mcf_pkg::*; #(
	parameter int NUM_PATHS   = NUM_PATHS_DEF,
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 ctl,
	output dp_stat_t                stat,
	input  logic [PATH_W-1:0]       path,
	input  logic [TIX_W-1:0]        tap_index,
	input  logic signed [VAL_W-1:0] value_re,
	input  logic signed [VAL_W-1:0] value_im,
	input  logic [TCNT_W-1:0]       tap_count,
	output logic signed [SUM_W-1:0] sum_re,
	output logic signed [SUM_W-1:0] sum_im
);

	localparam int DEPTH = NUM_PATHS * MAX_TAPS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIW   = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int SB    = SAMPLE_BITS;
	localparam int DW    = 2 * SB;
	localparam int XW    = 2 * SB + 1;

	// request decode
	logic                 path_ok;
	logic [PIW-1:0]       p_idx;
	logic [AW-1:0]        p_base;
	logic signed [SB-1:0] s_re, s_im;
	logic [CW-1:0]        tc_clamp, taps_eff;
	logic [TW-1:0]        wp_eff, wp_nxt;

	// per-path ring state
	logic                 started_q [NUM_PATHS];
	logic [CW-1:0]        ptaps_q   [NUM_PATHS];
	logic [TW-1:0]        wpos_q    [NUM_PATHS];

	// tap loop
	logic [AW-1:0]        base_q;
	logic [CW-1:0]        taps_q;
	logic [TW-1:0]        i_q, k_q;
	logic [AW-1:0]        clr_q;

	// memories
	logic [DW-1:0]        dmem [DEPTH];
	logic [DW-1:0]        wmem [DEPTH];
	logic                 d_we, w_we;
	logic [AW-1:0]        d_wa, w_wa;
	logic [DW-1:0]        d_wd, w_wd;

	// MAC pipe
	logic                 v_s1, v_s2;
	logic [DW-1:0]        wrd_s1, drd_s1;
	logic signed [SB-1:0] w_re, w_im, d_re, d_im;
	logic signed [DW-1:0] prr_s2, pii_s2, pir_s2, pri_s2;
	logic signed [XW-1:0] term_re, term_im;
	logic signed [SUM_W-1:0] acc_re_q, acc_im_q;

	assign path_ok = 32'(path) < NUM_PATHS;
	assign p_idx   = PIW'(path);
	assign p_base  = AW'(32'(p_idx) * MAX_TAPS);
	assign s_re    = SB'(value_re);
	assign s_im    = SB'(value_im);

	// tap count is latched once per path, forced into 1..MAX_TAPS
	always_comb begin
		if (tap_count == '0)
			tc_clamp = CW'(1);
		else if (32'(tap_count) > MAX_TAPS)
			tc_clamp = CW'(MAX_TAPS);
		else
			tc_clamp = CW'(tap_count);
	end

	assign taps_eff = started_q[p_idx] ? ptaps_q[p_idx] : tc_clamp;
	assign wp_eff   = started_q[p_idx] ? wpos_q[p_idx] : '0;
	assign wp_nxt   = (32'(wp_eff) + 1 >= 32'(taps_eff)) ? '0 : TW'(32'(wp_eff) + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NUM_PATHS; n++) begin
				started_q[n] <= 1'b0;
				ptaps_q[n]   <= '0;
				wpos_q[n]    <= '0;
			end
		end else if (ctl.load_sample) begin
			started_q[p_idx] <= 1'b1;
			ptaps_q[p_idx]   <= taps_eff;
			wpos_q[p_idx]    <= wp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (ctl.clear_step)
				clr_q <= AW'(32'(clr_q) + 1);
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	// tap loop: i walks weights upward, k walks the ring from newest to oldest
	always_ff @(posedge clk) begin
		if (ctl.load_sample) begin
			base_q <= p_base;
			taps_q <= taps_eff;
			i_q    <= '0;
			k_q    <= wp_eff;
		end else if (ctl.issue) begin
			i_q <= TW'(32'(i_q) + 1);
			k_q <= (k_q == '0) ? TW'(32'(taps_q) - 1) : TW'(32'(k_q) - 1);
		end
	end

	// write ports; the new sample lands before the first tap read
	always_comb begin
		d_we = ctl.clear_step || ctl.load_sample;
		d_wa = ctl.clear_step ? clr_q : AW'(32'(p_base) + 32'(wp_eff));
		d_wd = ctl.clear_step ? '0 : {s_re, s_im};
		w_we = ctl.clear_step || (ctl.load_weight && (32'(tap_index) < MAX_TAPS));
		w_wa = ctl.clear_step ? clr_q : AW'(32'(p_base) + 32'(tap_index));
		w_wd = ctl.clear_step ? '0 : {s_re, s_im};
	end

	always_ff @(posedge clk) begin
		if (d_we)
			dmem[d_wa] <= d_wd;
		if (ctl.issue)
			drd_s1 <= dmem[AW'(32'(base_q) + 32'(k_q))];
	end

	always_ff @(posedge clk) begin
		if (w_we)
			wmem[w_wa] <= w_wd;
		if (ctl.issue)
			wrd_s1 <= wmem[AW'(32'(base_q) + 32'(i_q))];
	end

	assign w_re = $signed(wrd_s1[DW-1:SB]);
	assign w_im = $signed(wrd_s1[SB-1:0]);
	assign d_re = $signed(drd_s1[DW-1:SB]);
	assign d_im = $signed(drd_s1[SB-1:0]);

	always_ff @(posedge clk) begin
		prr_s2 <= w_re * d_re;
		pii_s2 <= w_im * d_im;
		pir_s2 <= w_im * d_re;
		pri_s2 <= w_re * d_im;
	end

	assign term_re = XW'(prr_s2) - XW'(pii_s2);
	assign term_im = XW'(pir_s2) + XW'(pri_s2);

	// accumulator wraps modulo 2^SUM_W
	always_ff @(posedge clk) begin
		if (ctl.load_sample) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + SUM_W'(term_re);
			acc_im_q <= acc_im_q + SUM_W'(term_im);
		end
	end

	assign sum_re = acc_re_q;
	assign sum_im = acc_im_q;

	always_comb begin
		stat.path_ok    = path_ok;
		stat.clear_last = (32'(clr_q) == DEPTH - 1);
		stat.issue_last = (32'(i_q) + 1 == 32'(taps_q));
		stat.pipe_idle  = !v_s1 && !v_s2;
	end

endmodule

// ===== hdl/mcf_checker.sv =====
// ----------------------------------------------------------------------------
// mcf_checker
// Port-level checks of the request/result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcf_checker import mcf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic cmd,
	input logic busy,
	input logic done
);

	// a result only appears while the unit is busy with a sample
	`MCF_ASSERT(a_done_busy, clk, arst_n, done |-> busy, "done without busy")
	// result strobe lasts one cycle
	`MCF_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done held over two cycles")
	// unit is free right after a result
	`MCF_ASSERT(a_done_free, clk, arst_n, done |=> !busy, "busy after done")
	// a weight request never blocks the next one
	`MCF_ASSERT(a_wt_fast, clk, arst_n, (start && !busy && cmd == CMD_WEIGHT) |=> !busy, "weight request raised busy")
	// reset holds the unit busy with no result
	`MCF_ASSERT_NR(a_rst_busy, clk, !arst_n |-> (busy && !done), "not busy in reset")

endmodule

bind multipath_complex_fir_unit mcf_checker u_mcf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multipath_complex_fir_unit. Requests carry weight
// writes and samples; a behavioral copy of the per-path rings and weights
// predicts each complex sum, and the checker compares every done strobe
// against the oldest expected sum.
// ----------------------------------------------------------------------------
module tb_top;
	import mcf_pkg::*;

	localparam int NPATH = NUM_PATHS_DEF;
	localparam int NTAPS = MAX_TAPS_DEF;

	typedef struct {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} fir_sum_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	cmd_t                    cmd;
	logic [PATH_W-1:0]       path;
	logic [TIX_W-1:0]        tap_index;
	logic signed [VAL_W-1:0] value_re;
	logic signed [VAL_W-1:0] value_im;
	logic [TCNT_W-1:0]       tap_count;
	logic                    done;
	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;

	// behavioral copy of the unit's state
	logic signed [VAL_W-1:0] ring_re [NPATH][NTAPS];
	logic signed [VAL_W-1:0] ring_im [NPATH][NTAPS];
	logic signed [VAL_W-1:0] wgt_re  [NPATH][NTAPS];
	logic signed [VAL_W-1:0] wgt_im  [NPATH][NTAPS];
	int                      ring_pos   [NPATH];
	int                      path_len   [NPATH];
	bit                      path_live  [NPATH];

	fir_sum_t expected_sums [$];
	int       mismatch_count;
	bit       no_gaps;

	multipath_complex_fir_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.path      (path),
		.tap_index (tap_index),
		.value_re  (value_re),
		.value_im  (value_im),
		.tap_count (tap_count),
		.done      (done),
		.sum_re    (sum_re),
		.sum_im    (sum_im)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// Updates the state copy for one accepted request; returns 1 with the
	// complex sum when the request produces a result.
	function automatic bit fir_apply(input cmd_t c, input logic [PATH_W-1:0] p,
			input logic [TIX_W-1:0] tix, input logic signed [VAL_W-1:0] vr,
			input logic signed [VAL_W-1:0] vi, input logic [TCNT_W-1:0] tc,
			output fir_sum_t s);
		int     taps;
		int     wp;
		int     k;
		int     i;
		longint acc_re;
		longint acc_im;
		if (p >= NPATH)
			return 1'b0;
		if (c == CMD_WEIGHT) begin
			if (tix < NTAPS) begin
				wgt_re[p][tix] = vr;
				wgt_im[p][tix] = vi;
			end
			return 1'b0;
		end
		if (!path_live[p]) begin
			path_len[p]  = (tc == 0) ? 1 : (tc > NTAPS) ? NTAPS : int'(tc);
			ring_pos[p]  = 0;
			path_live[p] = 1'b1;
		end
		taps = path_len[p];
		wp   = ring_pos[p];
		ring_re[p][wp] = vr;
		ring_im[p][wp] = vi;
		acc_re = 0;
		acc_im = 0;
		k = wp;
		for (i = 0; i < taps; i++) begin
			acc_re += longint'(wgt_re[p][i]) * longint'(ring_re[p][k])
				- longint'(wgt_im[p][i]) * longint'(ring_im[p][k]);
			acc_im += longint'(wgt_im[p][i]) * longint'(ring_re[p][k])
				+ longint'(wgt_re[p][i]) * longint'(ring_im[p][k]);
			k = (k == 0) ? taps - 1 : k - 1;
		end
		s.re = acc_re[SUM_W-1:0];
		s.im = acc_im[SUM_W-1:0];
		ring_pos[p] = (wp + 1 >= taps) ? 0 : wp + 1;
		return 1'b1;
	endfunction

	function automatic int idle_gap();
		if (no_gaps || $urandom_range(0, 99) >= 25)
			return 0;
		return $urandom_range(1, 4);
	endfunction

	// mostly uniform, sometimes one of the corner values
	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 15))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return '0;
			3:       return -16'sd1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input cmd_t c, input logic [PATH_W-1:0] p,
			input logic [TIX_W-1:0] tix, input logic signed [VAL_W-1:0] vr,
			input logic signed [VAL_W-1:0] vi, input logic [TCNT_W-1:0] tc);
		int       gap;
		fir_sum_t s;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		path      <= p;
		tap_index <= tix;
		value_re  <= vr;
		value_im  <= vi;
		tap_count <= tc;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (fir_apply(c, p, tix, vr, vi, tc, s))
			expected_sums.push_back(s);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_sums.size() != 0)
			@(negedge clk);
	endtask

	// path 0: tap count zero becomes a single tap; later counts are ignored
	task automatic test_min_tap_count();
		send_request(CMD_WEIGHT, 3'd0, 6'd0, -16'sd32768, -16'sd32768, 7'd0);
		send_request(CMD_SAMPLE, 3'd0, 6'd0, -16'sd32768, -16'sd32768, 7'd0);
		send_request(CMD_SAMPLE, 3'd0, 6'd63, 16'sd32767, -16'sd32768, 7'd127);
	endtask

	// paths 1 and 7: counts above the maximum saturate to full length
	task automatic test_saturated_tap_count();
		send_request(CMD_WEIGHT, 3'd1, 6'd0, -16'sd32768, 16'sd32767, 7'd0);
		send_request(CMD_WEIGHT, 3'd1, 6'd63, 16'sd32767, 16'sd32767, 7'd127);
		send_request(CMD_SAMPLE, 3'd1, 6'd0, 16'sd32767, 16'sd32767, 7'd127);
		send_request(CMD_SAMPLE, 3'd1, 6'd63, -16'sd32768, -16'sd32768, 7'd1);
		send_request(CMD_WEIGHT, 3'd7, 6'd63, -16'sd32768, -16'sd32768, 7'd0);
		send_request(CMD_SAMPLE, 3'd7, 6'd0, -16'sd32768, -16'sd32768, 7'd65);
		send_request(CMD_SAMPLE, 3'd7, 6'd0, 16'sd0, -16'sd1, 7'd0);
	endtask

	// remaining paths start with short rings, last weight set first
	task automatic test_short_paths();
		int lens [5] = '{2, 3, 4, 5, 8};
		int p;
		for (p = 2; p <= 6; p++) begin
			send_request(CMD_WEIGHT, PATH_W'(p), TIX_W'(lens[p-2] - 1), rand_value(),
				rand_value(), 7'd0);
			send_request(CMD_SAMPLE, PATH_W'(p), 6'd0, rand_value(), rand_value(),
				TCNT_W'(lens[p-2]));
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		int   n;
		int   p;
		int   tix;
		cmd_t c;
		for (n = 0; n < n_items; n++) begin
			no_gaps = (n >= 200 && n < 350);
			if (n == 100 || n == 450)
				hold_until_drained();
			c = ($urandom_range(0, 99) < 35) ? CMD_WEIGHT : CMD_SAMPLE;
			if (c == CMD_WEIGHT) begin
				p = $urandom_range(0, NPATH - 1);
				// half the writes land on taps the path actually uses
				if ($urandom_range(0, 1))
					tix = $urandom_range(0, path_len[p] - 1);
				else
					tix = $urandom_range(0, NTAPS - 1);
			end else begin
				// the full-length paths are slow, keep them rare
				if ($urandom_range(0, 99) < 8)
					p = $urandom_range(0, 1) ? 1 : 7;
				else begin
					p = $urandom_range(0, 5);
					if (p >= 1)
						p = p + 1;
				end
				tix = $urandom_range(0, NTAPS - 1);
			end
			send_request(c, PATH_W'(p), TIX_W'(tix), rand_value(), rand_value(),
				TCNT_W'($urandom_range(0, 127)));
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin : chk_result
		fir_sum_t want;
		if (arst_n && done) begin
			if (expected_sums.size() == 0)
				report_mismatch($sformatf("unexpected result re=%0d im=%0d",
					sum_re, sum_im));
			else begin
				want = expected_sums.pop_front();
				if (sum_re !== want.re)
					report_mismatch($sformatf("sum_re got %0d want %0d", sum_re, want.re));
				if (sum_im !== want.im)
					report_mismatch($sformatf("sum_im got %0d want %0d", sum_im, want.im));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = CMD_WEIGHT;
		path           = '0;
		tap_index      = '0;
		value_re       = '0;
		value_im       = '0;
		tap_count      = '0;
		mismatch_count = 0;
		no_gaps        = 1'b0;
		foreach (ring_re[p, t]) begin
			ring_re[p][t] = '0;
			ring_im[p][t] = '0;
			wgt_re[p][t]  = '0;
			wgt_im[p][t]  = '0;
		end
		foreach (ring_pos[p]) begin
			ring_pos[p]  = 0;
			path_len[p]  = 1;
			path_live[p] = 1'b0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_min_tap_count();
		test_saturated_tap_count();
		test_short_paths();
		test_random_traffic(630);

		@(negedge clk);
		start <= 1'b0;
		while (expected_sums.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mcf_pkg.sv
hdl/mcf_ctrl.sv
hdl/mcf_dp.sv
hdl/multipath_complex_fir_unit.sv
hdl/mcf_checker.sv
verif/tb_top.sv
